>>> rtl/core/hsl_to_rgb_converter_macros.svh
// hsl_to_rgb_converter_macros.svh: assertion macros for the converter
// no dependencies; included by files that carry concurrent assertions

`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/hsl_pkg.sv
// hsl_pkg: widths, constants, sector codes and stage structs for the hsl to rgb converter
// no dependencies; imported by every rtl module and interface of the block

package hsl_pkg;

   localparam int UNIT_FRAC_BITS = 12;
   localparam int HUE_FRAC_BITS  = 6;

   localparam int HUE_W  = 16;
   localparam int UNIT_W = 13;
   localparam int CHAN_W = 8;

   localparam int UNIT_ONE    = 1 << UNIT_FRAC_BITS;
   localparam int U_W         = UNIT_FRAC_BITS + 1;
   localparam int NUM_SECTORS = 6;
   localparam int SECTOR_LEN  = 60 << HUE_FRAC_BITS;
   localparam int CIRCLE_LEN  = NUM_SECTORS * SECTOR_LEN;
   localparam int HR_W        = $clog2(CIRCLE_LEN);
   localparam int F_W         = $clog2(SECTOR_LEN + 1);

   // hue offset so the wrapped value is never negative
   localparam int HUE_SPAN  = 1 << (HUE_W - 1);
   localparam int HUE_WRAPS = (HUE_SPAN + CIRCLE_LEN - 1) / CIRCLE_LEN;
   localparam int HUE_OFS   = HUE_WRAPS * CIRCLE_LEN;
   localparam int HOFF_W    = $clog2(HUE_OFS + HUE_SPAN);
   localparam int Q_W       = $clog2((HUE_OFS + HUE_SPAN) / CIRCLE_LEN + 1);

   // reciprocal of the circle length for the quotient estimate
   localparam int     RECIP_SH = HOFF_W + 16;
   localparam longint RECIP    = (longint'(1) << RECIP_SH) / CIRCLE_LEN;
   localparam int     RECIP_W  = $clog2(RECIP + 1);
   localparam int     QP_W     = HOFF_W + RECIP_W;

   // channel value scale: full scale is 15 * 2^SCALE_SH
   localparam int CNUM_W   = 2 * UNIT_FRAC_BITS + 1;
   localparam int ACC_W    = 2 * UNIT_FRAC_BITS + 2;
   localparam int SCALE_SH = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 3;
   localparam int V_W      = SCALE_SH + 4;
   localparam int XP_W     = CNUM_W + F_W;
   localparam int RND_W    = SCALE_SH + 9;

   localparam logic [V_W-1:0] DENOM = V_W'(15) << SCALE_SH;

   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   typedef struct packed {
      logic              valid;
      logic [HR_W-1:0]   hue;
      logic [U_W-1:0]    light;
      logic [CNUM_W-1:0] chroma;
   } hc_stage_type;

   typedef struct packed {
      logic            valid;
      sector_type      sector;
      logic [V_W-1:0]  lo;
      logic [V_W-1:0]  hi;
      logic [XP_W-1:0] xprod;
   } sm_stage_type;

   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } px_stage_type;

endpackage

>>> rtl/core/hsl_req_if.sv
// hsl_req_if: valid/ready channel carrying one hsl pixel transaction
// depends on hsl_pkg

interface hsl_req_if import hsl_pkg::*;;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [UNIT_W-1:0] saturation;
   logic [UNIT_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

>>> rtl/core/hsl_rsp_if.sv
// hsl_rsp_if: valid/ready channel carrying one rgb pixel transaction
// depends on hsl_pkg

interface hsl_rsp_if import hsl_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/hsl_hue_chroma.sv
// hsl_hue_chroma: stages 1-2, hue wrap into one circle, clamping and chroma product
// depends on hsl_pkg

module hsl_hue_chroma import hsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [HUE_W-1:0]  in_hue,
   input  logic [UNIT_W-1:0] in_sat,
   input  logic [UNIT_W-1:0] in_light,
   output hc_stage_type      out_stage,
   input  logic              out_ready
);

   logic s1_en, s2_en;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;

   logic [HOFF_W-1:0] s1_hoff_ff, s1_hoff_in;
   logic [Q_W-1:0]    s1_q_ff, s1_q_in;
   logic [U_W-1:0]    s1_sat_ff, s1_sat_in;
   logic [U_W-1:0]    s1_light_ff, s1_light_in;
   logic [U_W-1:0]    s1_span_ff, s1_span_in;
   logic [QP_W-1:0]   qprod;
   logic [U_W:0]      two_l;

   logic [HR_W-1:0]   s2_hue_ff, s2_hue_in;
   logic [U_W-1:0]    s2_light_ff, s2_light_in;
   logic [CNUM_W-1:0] s2_chroma_ff, s2_chroma_in;
   logic [HOFF_W-1:0] hrem;

   assign s2_en    = !s2_valid_ff || out_ready;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   // stage 1
   assign s1_hoff_in  = {{(HOFF_W - HUE_W){in_hue[HUE_W-1]}}, in_hue} + HOFF_W'(HUE_OFS);
   assign qprod       = QP_W'(s1_hoff_in) * QP_W'(RECIP);
   assign s1_q_in     = Q_W'(qprod >> RECIP_SH);
   assign s1_sat_in   = (in_sat > UNIT_W'(UNIT_ONE)) ? U_W'(UNIT_ONE) : U_W'(in_sat);
   assign s1_light_in = (in_light > UNIT_W'(UNIT_ONE)) ? U_W'(UNIT_ONE) : U_W'(in_light);
   assign two_l       = {s1_light_in, 1'b0};
   assign s1_span_in  = (two_l >= (U_W + 1)'(UNIT_ONE))
                      ? U_W'((U_W + 1)'(2 * UNIT_ONE) - two_l) : U_W'(two_l);
   assign s1_valid_in = s1_en ? in_valid : s1_valid_ff;

   // stage 2
   assign hrem         = s1_hoff_ff - HOFF_W'(s1_q_ff) * HOFF_W'(CIRCLE_LEN);
   assign s2_hue_in    = (hrem >= HOFF_W'(CIRCLE_LEN))
                       ? HR_W'(hrem - HOFF_W'(CIRCLE_LEN)) : HR_W'(hrem);
   assign s2_chroma_in = CNUM_W'(s1_span_ff) * CNUM_W'(s1_sat_ff);
   assign s2_light_in  = s1_light_ff;
   assign s2_valid_in  = s2_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_hoff_ff  <= s1_hoff_in;
         s1_q_ff     <= s1_q_in;
         s1_sat_ff   <= s1_sat_in;
         s1_light_ff <= s1_light_in;
         s1_span_ff  <= s1_span_in;
      end
      if (s2_en) begin
         s2_hue_ff    <= s2_hue_in;
         s2_light_ff  <= s2_light_in;
         s2_chroma_ff <= s2_chroma_in;
      end
   end

   assign out_stage.valid  = s2_valid_ff;
   assign out_stage.hue    = s2_hue_ff;
   assign out_stage.light  = s2_light_ff;
   assign out_stage.chroma = s2_chroma_ff;

endmodule

>>> rtl/core/hsl_sector_mix.sv
// hsl_sector_mix: stages 3-4, hue sector, triangle factor, offset terms and secondary product
// depends on hsl_pkg

module hsl_sector_mix import hsl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hc_stage_type in_stage,
   output logic         in_ready,
   output sm_stage_type out_stage,
   input  logic         out_ready
);

   function automatic logic [HR_W-1:0] sector_start(input sector_type sec);
      logic [HR_W-1:0] start;
      case (sec)
         SEC_RY:  start = '0;
         SEC_YG:  start = HR_W'(SECTOR_LEN);
         SEC_GC:  start = HR_W'(2 * SECTOR_LEN);
         SEC_CB:  start = HR_W'(3 * SECTOR_LEN);
         SEC_BM:  start = HR_W'(4 * SECTOR_LEN);
         default: start = HR_W'(5 * SECTOR_LEN);
      endcase
      return start;
   endfunction

   logic s3_en, s4_en;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;

   logic [2:0]        sec_cnt;
   logic [HR_W-1:0]   start;
   logic [ACC_W-1:0]  two_lu;
   sector_type        s3_sector_ff, s3_sector_in;
   logic [F_W-1:0]    s3_f_ff, s3_f_in;
   logic [V_W-1:0]    s3_lo_ff, s3_lo_in;
   logic [V_W-1:0]    s3_hi_ff, s3_hi_in;
   logic [CNUM_W-1:0] s3_chroma_ff;

   sector_type        s4_sector_ff;
   logic [V_W-1:0]    s4_lo_ff, s4_hi_ff;
   logic [XP_W-1:0]   s4_xprod_ff, s4_xprod_in;

   assign s4_en    = !s4_valid_ff || out_ready;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_ready = s3_en;

   // stage 3
   always_comb begin
      sec_cnt = 3'd0;
      for (int k = 1; k < NUM_SECTORS; k++) begin
         if (in_stage.hue >= HR_W'(k * SECTOR_LEN)) begin
            sec_cnt = sec_cnt + 3'd1;
         end
      end
   end

   assign s3_sector_in = sector_type'(sec_cnt);
   assign start        = sector_start(s3_sector_in);
   assign s3_f_in      = sec_cnt[0] ? F_W'(start + HR_W'(SECTOR_LEN) - in_stage.hue)
                                    : F_W'(in_stage.hue - start);
   assign two_lu       = ACC_W'(in_stage.light) << (UNIT_FRAC_BITS + 1);
   assign s3_lo_in     = V_W'(two_lu - ACC_W'(in_stage.chroma)) * V_W'(SECTOR_LEN);
   assign s3_hi_in     = V_W'(two_lu + ACC_W'(in_stage.chroma)) * V_W'(SECTOR_LEN);
   assign s3_valid_in  = s3_en ? in_stage.valid : s3_valid_ff;

   // stage 4
   assign s4_xprod_in = XP_W'(s3_chroma_ff) * XP_W'(s3_f_ff);
   assign s4_valid_in = s4_en ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_sector_ff <= s3_sector_in;
         s3_f_ff      <= s3_f_in;
         s3_lo_ff     <= s3_lo_in;
         s3_hi_ff     <= s3_hi_in;
         s3_chroma_ff <= in_stage.chroma;
      end
      if (s4_en) begin
         s4_sector_ff <= s3_sector_ff;
         s4_lo_ff     <= s3_lo_ff;
         s4_hi_ff     <= s3_hi_ff;
         s4_xprod_ff  <= s4_xprod_in;
      end
   end

   assign out_stage.valid  = s4_valid_ff;
   assign out_stage.sector = s4_sector_ff;
   assign out_stage.lo     = s4_lo_ff;
   assign out_stage.hi     = s4_hi_ff;
   assign out_stage.xprod  = s4_xprod_ff;

endmodule

>>> rtl/core/hsl_scale_round.sv
// hsl_scale_round: stages 5-6, channel selection by sector, scale by 255 and round half up
// depends on hsl_pkg

module hsl_scale_round import hsl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sm_stage_type in_stage,
   output logic         in_ready,
   output px_stage_type out_stage,
   input  logic         out_ready
);

   // full scale is 15 * 2^SCALE_SH, so 255 / full scale reduces to 17 / 2^SCALE_SH
   function automatic logic [CHAN_W-1:0] scale_round(input logic [V_W-1:0] v);
      logic [RND_W-1:0] acc;
      acc = (RND_W'(v) << 4) + RND_W'(v) + (RND_W'(1) << (SCALE_SH - 1));
      return CHAN_W'(acc >> SCALE_SH);
   endfunction

   logic s5_en, s6_en;
   logic s5_valid_ff, s5_valid_in;
   logic s6_valid_ff, s6_valid_in;

   logic [V_W-1:0]    mid;
   logic [V_W-1:0]    s5_r_ff, s5_r_in;
   logic [V_W-1:0]    s5_g_ff, s5_g_in;
   logic [V_W-1:0]    s5_b_ff, s5_b_in;
   logic [CHAN_W-1:0] s6_r_ff, s6_g_ff, s6_b_ff;

   assign s6_en    = !s6_valid_ff || out_ready;
   assign s5_en    = !s5_valid_ff || s6_en;
   assign in_ready = s5_en;

   // stage 5
   assign mid = in_stage.lo + (V_W'(in_stage.xprod) << 1);

   always_comb begin
      case (in_stage.sector)
         SEC_RY: begin
            s5_r_in = in_stage.hi;
            s5_g_in = mid;
            s5_b_in = in_stage.lo;
         end
         SEC_YG: begin
            s5_r_in = mid;
            s5_g_in = in_stage.hi;
            s5_b_in = in_stage.lo;
         end
         SEC_GC: begin
            s5_r_in = in_stage.lo;
            s5_g_in = in_stage.hi;
            s5_b_in = mid;
         end
         SEC_CB: begin
            s5_r_in = in_stage.lo;
            s5_g_in = mid;
            s5_b_in = in_stage.hi;
         end
         SEC_BM: begin
            s5_r_in = mid;
            s5_g_in = in_stage.lo;
            s5_b_in = in_stage.hi;
         end
         default: begin
            s5_r_in = in_stage.hi;
            s5_g_in = in_stage.lo;
            s5_b_in = mid;
         end
      endcase
   end

   assign s5_valid_in = s5_en ? in_stage.valid : s5_valid_ff;
   assign s6_valid_in = s6_en ? s5_valid_ff : s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_r_ff <= s5_r_in;
         s5_g_ff <= s5_g_in;
         s5_b_ff <= s5_b_in;
      end
      if (s6_en) begin
         s6_r_ff <= scale_round(s5_r_ff);
         s6_g_ff <= scale_round(s5_g_ff);
         s6_b_ff <= scale_round(s5_b_ff);
      end
   end

   assign out_stage.valid = s6_valid_ff;
   assign out_stage.red   = s6_r_ff;
   assign out_stage.green = s6_g_ff;
   assign out_stage.blue  = s6_b_ff;

endmodule

>>> rtl/core/hsl_to_rgb_converter.sv
// hsl_to_rgb_converter: top level, six register stages between the req and rsp channels
// an accepted req transaction passes through stages 1 to 6 in order to rsp valid
// throughput one transaction per cycle while rsp is ready; each stage loads whenever it is empty or drains
// synchronous active-high reset clears the stage valid bits, datapath registers are not reset
// depends on hsl_pkg, hsl_req_if, hsl_rsp_if, hsl_hue_chroma, hsl_sector_mix, hsl_scale_round

`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter import hsl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hsl_req_if.sink   req_if,
   hsl_rsp_if.source rsp_if
);

   hc_stage_type hc;
   sm_stage_type sm;
   px_stage_type px;
   logic         hc_ready;
   logic         sm_ready;

   hsl_hue_chroma u_hue_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_hue    (req_if.hue),
      .in_sat    (req_if.saturation),
      .in_light  (req_if.lightness),
      .out_stage (hc),
      .out_ready (hc_ready)
   );

   hsl_sector_mix u_sector_mix (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (hc),
      .in_ready  (hc_ready),
      .out_stage (sm),
      .out_ready (sm_ready)
   );

   hsl_scale_round u_scale_round (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (sm),
      .in_ready  (sm_ready),
      .out_stage (px),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.valid = px.valid;
   assign rsp_if.red   = px.red;
   assign rsp_if.green = px.green;
   assign rsp_if.blue  = px.blue;

   `HSL_ASSERT_NOW(a_hue_wrapped, clock, reset, hc.valid, hc.hue < HR_W'(CIRCLE_LEN), "hue not wrapped into one circle")
   `HSL_ASSERT_NOW(a_terms_ordered, clock, reset, sm.valid, (sm.lo <= sm.hi) && (sm.hi <= DENOM), "offset terms out of order or above full scale")
   `HSL_ASSERT_NEXT(a_chroma_hold, clock, reset, hc.valid && !hc_ready, hc.valid && $stable(hc.chroma) && $stable(hc.hue), "stalled chroma stage changed")
   `HSL_ASSERT_NEXT(a_mix_hold, clock, reset, sm.valid && !sm_ready, sm.valid && $stable(sm.hi) && $stable(sm.xprod), "stalled mix stage changed")

endmodule

>>> dv/tb.sv
// tb: self-checking testbench for the hsl to rgb converter, directed pixels then random streams
// with and without random source gaps and sink stalls; results are checked against an exact integer predictor
// depends on hsl_pkg, hsl_req_if, hsl_rsp_if and hsl_to_rgb_converter

module tb import hsl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

   logic clock = 1'b0;
   logic reset;

   hsl_req_if req_if ();
   hsl_rsp_if rsp_if ();

   hsl_to_rgb_converter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   rgb_pixel_type rgb_expected[$];
   rgb_pixel_type rgb_want;
   int            mismatches   = 0;
   int            stall_cycles = 0;
   bit            source_gaps  = 1'b0;
   bit            sink_stalls  = 1'b0;

   always #2 clock = ~clock;

   function automatic logic [CHAN_W-1:0] to_channel(longint unsigned v, longint unsigned d);
      return CHAN_W'((v * 255 + d / 2) / d);
   endfunction

   function automatic rgb_pixel_type rgb_from_hsl(logic [HUE_W-1:0] hue,
                                                  logic [UNIT_W-1:0] sat_in,
                                                  logic [UNIT_W-1:0] light_in);
      longint          angle;
      longint unsigned sat, light, spread, chroma, ramp, denom, full, part, base;
      longint unsigned r, g, b;
      rgb_pixel_type   px;
      angle = longint'($signed(hue)) % CIRCLE_LEN;
      if (angle < 0) angle += CIRCLE_LEN;
      sat    = (sat_in > UNIT_ONE) ? UNIT_ONE : sat_in;
      light  = (light_in > UNIT_ONE) ? UNIT_ONE : light_in;
      spread = (2 * light >= UNIT_ONE) ? 2 * light - UNIT_ONE : UNIT_ONE - 2 * light;
      chroma = (UNIT_ONE - spread) * sat;
      ramp   = angle % (2 * SECTOR_LEN);
      if (ramp >= SECTOR_LEN) ramp = 2 * SECTOR_LEN - ramp;
      denom = 64'd2 * UNIT_ONE * UNIT_ONE * SECTOR_LEN;
      full  = 2 * chroma * SECTOR_LEN;
      part  = 2 * chroma * ramp;
      base  = 2 * light * UNIT_ONE * SECTOR_LEN - chroma * SECTOR_LEN;
      case (sector_type'(angle / SECTOR_LEN))
         SEC_RY: begin r = full; g = part; b = 0;    end
         SEC_YG: begin r = part; g = full; b = 0;    end
         SEC_GC: begin r = 0;    g = full; b = part; end
         SEC_CB: begin r = 0;    g = part; b = full; end
         SEC_BM: begin r = part; g = 0;    b = full; end
         default: begin r = full; g = 0;    b = part; end
      endcase
      px.red   = to_channel(r + base, denom);
      px.green = to_channel(g + base, denom);
      px.blue  = to_channel(b + base, denom);
      return px;
   endfunction

   // biased toward sector boundaries now and then
   function automatic logic [HUE_W-1:0] pick_hue();
      if ($urandom_range(0, 3) == 0)
         return HUE_W'((int'($urandom_range(0, 16)) - 8) * SECTOR_LEN
                       + int'($urandom_range(0, 2)) - 1);
      return HUE_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [UNIT_W-1:0] pick_unit();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 6))
               0: return UNIT_W'(0);
               1: return UNIT_W'(1);
               2: return UNIT_W'(UNIT_ONE / 2);
               3: return UNIT_W'(UNIT_ONE - 1);
               4: return UNIT_W'(UNIT_ONE);
               5: return UNIT_W'(UNIT_ONE + 1);
               default: return UNIT_W'(8191);
            endcase
         1, 2: return UNIT_W'($urandom_range(UNIT_ONE + 1, 8191));
         default: return UNIT_W'($urandom_range(0, UNIT_ONE));
      endcase
   endfunction

   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [UNIT_W-1:0] sat,
                             input logic [UNIT_W-1:0] light);
      if (source_gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.hue        <= hue;
      req_if.saturation <= sat;
      req_if.lightness  <= light;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic test_directed();
      int                k;
      logic [UNIT_W-1:0] sat_full;
      logic [UNIT_W-1:0] light_half;
      sat_full    = UNIT_W'(UNIT_ONE);
      light_half  = UNIT_W'(UNIT_ONE / 2);
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      for (k = 0; k < NUM_SECTORS; k++)
         send_pixel(HUE_W'(k * SECTOR_LEN), sat_full, light_half);
      send_pixel(HUE_W'(SECTOR_LEN / 2), sat_full, light_half);
      send_pixel(HUE_W'(CIRCLE_LEN - 1), sat_full, light_half);
      send_pixel(HUE_W'(CIRCLE_LEN), sat_full, light_half);
      send_pixel(HUE_W'(-1), sat_full, light_half);
      send_pixel(HUE_W'(-32768), sat_full, light_half);
      send_pixel(HUE_W'(32767), sat_full, light_half);
      send_pixel(HUE_W'(-CIRCLE_LEN), UNIT_W'(3000), UNIT_W'(1500));
      // exact half on every channel
      send_pixel(HUE_W'(0), UNIT_W'(0), light_half);
      send_pixel(HUE_W'(9000), UNIT_W'(0), UNIT_W'(0));
      send_pixel(HUE_W'(9000), sat_full, sat_full);
      send_pixel(HUE_W'(9000), UNIT_W'(8191), UNIT_W'(8191));
      send_pixel(HUE_W'(12345), UNIT_W'(UNIT_ONE + 1), UNIT_W'(UNIT_ONE + 1));
      send_pixel(HUE_W'(20000), UNIT_W'(8191), UNIT_W'(1000));
      send_pixel(HUE_W'(5000), UNIT_W'(1000), UNIT_W'(8191));
      send_pixel(HUE_W'(5000), sat_full, UNIT_W'(1));
      send_pixel(HUE_W'(5000), UNIT_W'(1), UNIT_W'(UNIT_ONE - 1));
      send_pixel(HUE_W'(-9000), UNIT_W'(UNIT_ONE / 2), UNIT_W'(UNIT_ONE / 4));
   endtask

   task automatic test_random_idling(input int count);
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      repeat (count) send_pixel(pick_hue(), pick_unit(), pick_unit());
   endtask

   task automatic test_random_streaming(input int count);
      source_gaps = 1'b0;
      sink_stalls = 1'b0;
      repeat (count) send_pixel(pick_hue(), pick_unit(), pick_unit());
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         rgb_expected.push_back(rgb_from_hsl(req_if.hue, req_if.saturation, req_if.lightness));
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rgb_expected.size() == 0) begin
            $error("unexpected transaction red %0d green %0d blue %0d",
                   rsp_if.red, rsp_if.green, rsp_if.blue);
            mismatches++;
         end else begin
            rgb_want = rgb_expected.pop_front();
            if (rsp_if.red !== rgb_want.red) begin
               $error("red expected %0d actual %0d", rgb_want.red, rsp_if.red);
               mismatches++;
            end
            if (rsp_if.green !== rgb_want.green) begin
               $error("green expected %0d actual %0d", rgb_want.green, rsp_if.green);
               mismatches++;
            end
            if (rsp_if.blue !== rgb_want.blue) begin
               $error("blue expected %0d actual %0d", rgb_want.blue, rsp_if.blue);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.hue        <= '0;
      req_if.saturation <= '0;
      req_if.lightness  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_idling(680);
      test_random_streaming(300);
      req_if.valid <= 1'b0;
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && rgb_expected.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hsl_pkg.sv
rtl/core/hsl_req_if.sv
rtl/core/hsl_rsp_if.sv
rtl/core/hsl_hue_chroma.sv
rtl/core/hsl_sector_mix.sv
rtl/core/hsl_scale_round.sv
rtl/core/hsl_to_rgb_converter.sv
dv/tb.sv
